// ----- rtl/btcd_pkg.sv -----
// ----------------------------------------------------------------------------
// btcd_pkg
// Shared types, constants and tables of the button tap, long-press and chord
// detector.
// ----------------------------------------------------------------------------
package btcd_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_BUTTONS     = 4;
  localparam int BTN_W           = 2;
  localparam int SLOT_W          = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int EVQ_DEPTH       = 8;

  localparam logic [15:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [15:0] TAP_WINDOW_RST  = 16'd300;
  localparam logic [15:0] CHORD_WINDOW_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS   = 3'd0,
    REG_TAP_WINDOW   = 3'd1,
    REG_CHORD_WINDOW = 3'd2,
    REG_DOUBLE       = 3'd3,
    REG_TRIPLE       = 3'd4,
    REG_LONG         = 3'd5,
    REG_CHORD_LOW    = 3'd6,
    REG_CHORD_HIGH   = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_HELD     = 4'b0010,
    PH_AWAIT    = 4'b0100,
    PH_CONSUMED = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    EV_SINGLE = 3'd0,
    EV_DOUBLE = 3'd1,
    EV_TRIPLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_CHORD  = 3'd4
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e         kind;
    logic [BTN_W-1:0] first;
    logic [BTN_W-1:0] second;
    logic [7:0]       modifier;
    logic [7:0]       key;
    logic             last;
  } event_t;

  // Event proposed by one button for the current tick.
  typedef struct packed {
    logic              valid;
    ev_kind_e          kind;
    logic [SLOT_W-1:0] action;
  } btn_ev_t;

  // Slot of a button pair in the concatenated chord action registers.
  function automatic logic [2:0] chord_slot_idx(input logic [BTN_W-1:0] a,
                                                input logic [BTN_W-1:0] b);
    logic [2:0] idx;
    unique case ({a, b})
      4'b0001: idx = 3'd0;
      4'b0010: idx = 3'd1;
      4'b0011: idx = 3'd2;
      4'b0110: idx = 3'd3;
      4'b0111: idx = 3'd4;
      4'b1011: idx = 3'd5;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/btcd_button.sv -----
// ----------------------------------------------------------------------------
// btcd_button
// Next-state logic of one button: tap counting, hold timing and the event
// that the button gives on this tick.
// ----------------------------------------------------------------------------
module btcd_button import btcd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 edge_i,
  input  logic                 held_i,
  input  logic                 prev_i,
  input  logic                 mapped_i,
  input  phase_e               phase_i,
  input  logic [TIME_BITS-1:0] start_i,
  input  logic [TIME_BITS-1:0] rel_i,
  input  logic [7:0]           count_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [15:0]          long_press_ms_i,
  input  logic [15:0]          tap_window_ms_i,
  input  logic [SLOT_W-1:0]    double_slot_i,
  input  logic [SLOT_W-1:0]    triple_slot_i,
  input  logic [SLOT_W-1:0]    long_slot_i,
  output phase_e               phase_o,
  output logic [TIME_BITS-1:0] start_o,
  output logic [TIME_BITS-1:0] rel_o,
  output logic [7:0]           count_o,
  output btn_ev_t              ev_o
);

  logic                 release_w;
  logic [TIME_BITS-1:0] hold_time;
  logic [TIME_BITS-1:0] idle_time;

  assign release_w = prev_i && !held_i;
  assign hold_time = now_i - start_i;
  assign idle_time = now_i - rel_i;

  always_comb begin
    phase_o = phase_i;
    start_o = start_i;
    rel_o   = rel_i;
    count_o = count_i;
    ev_o    = '{valid: 1'b0, kind: EV_SINGLE, action: '0};
    if (!mapped_i) begin
      ev_o.valid = edge_i;
      phase_o    = PH_IDLE;
      count_o    = 8'd0;
    end else begin
      unique case (phase_i)
        PH_IDLE: begin
          if (edge_i) begin
            phase_o = PH_HELD;
            start_o = now_i;
            count_o = 8'd1;
          end
        end
        PH_HELD: begin
          if (release_w) begin
            if (hold_time >= TIME_BITS'(long_press_ms_i)) begin
              ev_o.valid = 1'b1;
              if (long_slot_i != '0) begin
                ev_o.kind   = EV_LONG;
                ev_o.action = long_slot_i;
              end
              phase_o = PH_IDLE;
              count_o = 8'd0;
            end else begin
              rel_o   = now_i;
              phase_o = PH_AWAIT;
            end
          end
        end
        PH_AWAIT: begin
          if (edge_i) begin
            if (count_i != 8'hFF) begin
              count_o = count_i + 8'd1;
            end
            phase_o = PH_HELD;
            start_o = now_i;
          end else if (idle_time > TIME_BITS'(tap_window_ms_i)) begin
            // Double and triple counts without a mapping, and higher counts, give nothing.
            if (count_i == 8'd2 && double_slot_i != '0) begin
              ev_o = '{valid: 1'b1, kind: EV_DOUBLE, action: double_slot_i};
            end else if (count_i == 8'd3 && triple_slot_i != '0) begin
              ev_o = '{valid: 1'b1, kind: EV_TRIPLE, action: triple_slot_i};
            end else if (count_i == 8'd1) begin
              ev_o.valid = 1'b1;
            end
            phase_o = PH_IDLE;
            count_o = 8'd0;
          end
        end
        default: begin
          if (release_w) begin
            phase_o = PH_IDLE;
            count_o = 8'd0;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/btcd_chord.sv -----
// ----------------------------------------------------------------------------
// btcd_chord
// Chord resolution: pairs of held buttons whose press starts lie within the
// chord window, lower button first, each button in at most one chord.
// ----------------------------------------------------------------------------
module btcd_chord import btcd_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic [NUM_BUTTONS-1:0] held_i,
  input  logic [TIME_BITS-1:0]   start_i [NUM_BUTTONS],
  input  logic [15:0]            chord_window_ms_i,
  input  logic [6*SLOT_W-1:0]    chord_actions_i,
  output logic [NUM_BUTTONS-1:0] consumed_o,
  output logic [NUM_BUTTONS-2:0] ev_vld_o,
  output event_t [NUM_BUTTONS-2:0] ev_o
);

  logic              pair_ok  [NUM_BUTTONS][NUM_BUTTONS];
  logic [SLOT_W-1:0] pair_act [NUM_BUTTONS][NUM_BUTTONS];

  // Every pair is judged in parallel; the shorter modular distance counts.
  always_comb begin
    logic [TIME_BITS-1:0] d1;
    logic [TIME_BITS-1:0] d2;
    logic [TIME_BITS-1:0] span;
    for (int a = 0; a < NUM_BUTTONS; a++) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        d1   = start_i[a] - start_i[b];
        d2   = start_i[b] - start_i[a];
        span = (d1 < d2) ? d1 : d2;
        pair_act[a][b] = '0;
        pair_ok[a][b]  = 1'b0;
        if (a < b) begin
          pair_act[a][b] = chord_actions_i[SLOT_W*chord_slot_idx(BTN_W'(a), BTN_W'(b)) +:
                                           SLOT_W];
          pair_ok[a][b]  = (span <= TIME_BITS'(chord_window_ms_i)) &&
                           (pair_act[a][b] != '0);
        end
      end
    end
  end

  always_comb begin
    logic [NUM_BUTTONS-1:0] live;
    logic                   found;
    live       = held_i;
    consumed_o = '0;
    ev_vld_o   = '0;
    ev_o       = '0;
    for (int a = 0; a < NUM_BUTTONS - 1; a++) begin
      found = 1'b0;
      if (live[a]) begin
        for (int b = a + 1; b < NUM_BUTTONS; b++) begin
          if (!found && live[b] && pair_ok[a][b]) begin
            found          = 1'b1;
            live[a]        = 1'b0;
            live[b]        = 1'b0;
            consumed_o[a]  = 1'b1;
            consumed_o[b]  = 1'b1;
            ev_vld_o[a]    = 1'b1;
            ev_o[a].kind     = EV_CHORD;
            ev_o[a].first    = BTN_W'(a);
            ev_o[a].second   = BTN_W'(b);
            ev_o[a].modifier = pair_act[a][b][15:8];
            ev_o[a].key      = pair_act[a][b][7:0];
            ev_o[a].last     = 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/btcd_evq.sv -----
// ----------------------------------------------------------------------------
// btcd_evq
// Event queue: packs the events of one tick in order, marks the final one and
// hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module btcd_evq import btcd_pkg::*; #(
  parameter int NCAND  = 7,
  parameter int MAX_EV = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [NCAND-1:0] cand_vld_i,
  input  event_t [NCAND-1:0] cand_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output event_t           out_o
);

  localparam int PTR_W = $clog2(EVQ_DEPTH);
  localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

  event_t             ent_q [EVQ_DEPTH];
  event_t             ent_d [EVQ_DEPTH];
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_left;
  logic [CNT_W-1:0]   n_push;
  logic [PTR_W-1:0]   wr_idx;
  logic               pop;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign cnt_left    = cnt_q - CNT_W'(pop);
  assign room_o      = ({1'b0, cnt_left} + (CNT_W+1)'(MAX_EV)) <= (CNT_W+1)'(EVQ_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = ent_q[head_q];

  always_comb begin
    ent_d  = ent_q;
    n_push = '0;
    wr_idx = tail_q;
    if (push_i) begin
      for (int c = 0; c < NCAND; c++) begin
        if (cand_vld_i[c]) begin
          wr_idx            = tail_q + n_push[PTR_W-1:0];
          ent_d[wr_idx]      = cand_i[c];
          ent_d[wr_idx].last = 1'b0;
          n_push            = n_push + CNT_W'(1);
        end
      end
      // The final event of the tick carries the last flag.
      if (n_push != '0) begin
        ent_d[wr_idx].last = 1'b1;
      end
    end
    head_d = head_q + PTR_W'(pop);
    tail_d = tail_q + n_push[PTR_W-1:0];
    cnt_d  = cnt_left + n_push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ----- rtl/button_tap_long_chord_detector.sv -----
// ----------------------------------------------------------------------------
// button_tap_long_chord_detector
// Top level: configuration registers, tick register, button state and the
// event queue.
// ----------------------------------------------------------------------------
// A tick is taken into an input register and, once the event queue has room,
// all buttons and chords are resolved at once and the resulting events (none
// to four) are written into an eight-entry event queue. The queue hands out one
// event per cycle while out_ready_i is high, with last_event set on the final
// event of each tick, and a new tick is accepted every cycle as long as the
// queue has room for a full tick's worth of events. Configuration writes are
// taken at once and apply to every tick that is processed afterwards.
module button_tap_long_chord_detector import btcd_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            press_edge_mask_i,
  input  logic [3:0]            pressed_mask_i,
  input  logic [31:0]           now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            event_kind_o,
  output logic [1:0]            first_button_o,
  output logic [1:0]            second_button_o,
  output logic [7:0]            modifier_code_o,
  output logic [7:0]            key_code_o,
  output logic                  last_event_o
);

  localparam int NCAND  = 2 * NUM_BUTTONS - 1;
  localparam int MAX_EV = NUM_BUTTONS + NUM_BUTTONS / 2;

  // Configuration registers.
  logic [15:0] long_press_q, tap_window_q, chord_window_q;
  logic [63:0] double_q, triple_q, long_q, chord_low_q;
  logic [31:0] chord_high_q;
  logic [6*SLOT_W-1:0] chord_acts;

  // Tick register.
  logic                  in_vld_q;
  logic [3:0]            edges_q, levels_q;
  logic [TIME_BITS-1:0]  now_q;
  logic                  proc, room;

  // Button state.
  phase_e               phase_q [NUM_BUTTONS];
  logic [TIME_BITS-1:0] start_q [NUM_BUTTONS];
  logic [TIME_BITS-1:0] rel_q   [NUM_BUTTONS];
  logic [7:0]           count_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] prev_q;

  phase_e               phase_d [NUM_BUTTONS];
  logic [TIME_BITS-1:0] start_d [NUM_BUTTONS];
  logic [TIME_BITS-1:0] rel_d   [NUM_BUTTONS];
  logic [7:0]           count_d [NUM_BUTTONS];
  btn_ev_t              btn_ev  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] mapped;
  logic [NUM_BUTTONS-1:0] held_after;
  logic [NUM_BUTTONS-1:0] consumed;

  logic [NUM_BUTTONS-2:0]   chord_vld;
  event_t [NUM_BUTTONS-2:0] chord_ev;
  logic [NCAND-1:0]         cand_vld;
  event_t [NCAND-1:0]       cand;
  event_t                   out_ev;

  assign cfg_ready_o = 1'b1;
  assign chord_acts  = {chord_high_q, chord_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q   <= LONG_PRESS_RST;
      tap_window_q   <= TAP_WINDOW_RST;
      chord_window_q <= CHORD_WINDOW_RST;
      double_q       <= '0;
      triple_q       <= '0;
      long_q         <= '0;
      chord_low_q    <= '0;
      chord_high_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LONG_PRESS:   long_press_q   <= cfg_data_i[15:0];
        REG_TAP_WINDOW:   tap_window_q   <= cfg_data_i[15:0];
        REG_CHORD_WINDOW: chord_window_q <= cfg_data_i[15:0];
        REG_DOUBLE:       double_q       <= cfg_data_i;
        REG_TRIPLE:       triple_q       <= cfg_data_i;
        REG_LONG:         long_q         <= cfg_data_i;
        REG_CHORD_LOW:    chord_low_q    <= cfg_data_i;
        REG_CHORD_HIGH:   chord_high_q   <= cfg_data_i[31:0];
        default:          ;
      endcase
    end
  end

  // A tick is resolved once the queue can take all events it may cause.
  assign proc       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      edges_q  <= press_edge_mask_i;
      levels_q <= pressed_mask_i;
      now_q    <= now_ms_i[TIME_BITS-1:0];
    end
  end

  // A button with any tap, long or chord mapping runs its phase machine.
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      mapped[i] = (double_q[SLOT_W*i +: SLOT_W] != '0) ||
                  (triple_q[SLOT_W*i +: SLOT_W] != '0) ||
                  (long_q[SLOT_W*i +: SLOT_W] != '0);
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        if (j < i && chord_acts[SLOT_W*chord_slot_idx(BTN_W'(j), BTN_W'(i)) +: SLOT_W] != '0)
        begin
          mapped[i] = 1'b1;
        end
        if (j > i && chord_acts[SLOT_W*chord_slot_idx(BTN_W'(i), BTN_W'(j)) +: SLOT_W] != '0)
        begin
          mapped[i] = 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    btcd_button #(
      .TIME_BITS (TIME_BITS)
    ) u_button (
      .edge_i          (edges_q[g]),
      .held_i          (levels_q[g]),
      .prev_i          (prev_q[g]),
      .mapped_i        (mapped[g]),
      .phase_i         (phase_q[g]),
      .start_i         (start_q[g]),
      .rel_i           (rel_q[g]),
      .count_i         (count_q[g]),
      .now_i           (now_q),
      .long_press_ms_i (long_press_q),
      .tap_window_ms_i (tap_window_q),
      .double_slot_i   (double_q[SLOT_W*g +: SLOT_W]),
      .triple_slot_i   (triple_q[SLOT_W*g +: SLOT_W]),
      .long_slot_i     (long_q[SLOT_W*g +: SLOT_W]),
      .phase_o         (phase_d[g]),
      .start_o         (start_d[g]),
      .rel_o           (rel_d[g]),
      .count_o         (count_d[g]),
      .ev_o            (btn_ev[g])
    );
    assign held_after[g] = phase_d[g] == PH_HELD;
    assign cand_vld[g]   = btn_ev[g].valid;
    assign cand[g]       = '{kind: btn_ev[g].kind, first: BTN_W'(g), second: '0,
                             modifier: btn_ev[g].action[15:8],
                             key: btn_ev[g].action[7:0], last: 1'b0};
  end

  btcd_chord #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_chord (
    .held_i            (held_after),
    .start_i           (start_d),
    .chord_window_ms_i (chord_window_q),
    .chord_actions_i   (chord_acts),
    .consumed_o        (consumed),
    .ev_vld_o          (chord_vld),
    .ev_o              (chord_ev)
  );

  assign cand_vld[NCAND-1:NUM_BUTTONS] = chord_vld;
  assign cand[NCAND-1:NUM_BUTTONS]     = chord_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_q[i] <= PH_IDLE;
        start_q[i] <= '0;
        rel_q[i]   <= '0;
        count_q[i] <= '0;
      end
    end else if (proc) begin
      prev_q <= levels_q[NUM_BUTTONS-1:0];
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_q[i] <= consumed[i] ? PH_CONSUMED : phase_d[i];
        start_q[i] <= start_d[i];
        rel_q[i]   <= rel_d[i];
        count_q[i] <= consumed[i] ? 8'd0 : count_d[i];
      end
    end
  end

  btcd_evq #(
    .NCAND  (NCAND),
    .MAX_EV (MAX_EV)
  ) u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (proc),
    .cand_vld_i  (cand_vld),
    .cand_i      (cand),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_ev)
  );

  assign event_kind_o    = out_ev.kind;
  assign first_button_o  = out_ev.first;
  assign second_button_o = out_ev.second;
  assign modifier_code_o = out_ev.modifier;
  assign key_code_o      = out_ev.key;
  assign last_event_o    = out_ev.last;

endmodule

// ----- tb/tb_button_tap_long_chord_detector.sv -----
// ----------------------------------------------------------------------------
// tb_button_tap_long_chord_detector
// Drives button ticks into the detector and checks every event that comes
// out against a cycle-free prediction of the tap, long-press and chord rules.
// ----------------------------------------------------------------------------
module tb_button_tap_long_chord_detector import btcd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES     = 80;
  localparam int EVENTS_PER_TICK = 6;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_TICKS    = 23;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [3:0]            press_edge_mask_i;
  logic [3:0]            pressed_mask_i;
  logic [31:0]           now_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [2:0]            event_kind_o;
  logic [1:0]            first_button_o;
  logic [1:0]            second_button_o;
  logic [7:0]            modifier_code_o;
  logic [7:0]            key_code_o;
  logic                  last_event_o;

  button_tap_long_chord_detector dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .press_edge_mask_i (press_edge_mask_i),
    .pressed_mask_i    (pressed_mask_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_kind_o      (event_kind_o),
    .first_button_o    (first_button_o),
    .second_button_o   (second_button_o),
    .modifier_code_o   (modifier_code_o),
    .key_code_o        (key_code_o),
    .last_event_o      (last_event_o)
  );

  // Mirror of the detector registers and per-button state.
  logic [15:0] thr_long_press;
  logic [15:0] thr_tap_window;
  logic [15:0] thr_chord_window;
  logic [63:0] act_double;
  logic [63:0] act_triple;
  logic [63:0] act_long;
  logic [63:0] act_chord_lo;
  logic [31:0] act_chord_hi;

  phase_e      btn_phase   [4];
  logic [31:0] btn_press_t [4];
  logic [31:0] btn_release_t [4];
  logic [7:0]  btn_taps    [4];
  logic        btn_prev    [4];

  event_t tick_events[$];
  event_t expected_events[$];
  event_t oldest_event;

  int   error_count      = 0;
  bit   no_gaps          = 1'b0;
  bit   hold_receiver    = 1'b0;
  logic [31:0] sim_now;
  logic [3:0]  sim_held;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  task automatic clear_prediction();
    thr_long_press   = LONG_PRESS_RST;
    thr_tap_window   = TAP_WINDOW_RST;
    thr_chord_window = CHORD_WINDOW_RST;
    act_double       = '0;
    act_triple       = '0;
    act_long         = '0;
    act_chord_lo     = '0;
    act_chord_hi     = '0;
    for (int i = 0; i < 4; i++) begin
      btn_phase[i]     = PH_IDLE;
      btn_press_t[i]   = '0;
      btn_release_t[i] = '0;
      btn_taps[i]      = '0;
      btn_prev[i]      = 1'b0;
    end
  endtask

  task automatic apply_reg(input cfg_reg_e idx, input logic [63:0] data);
    case (idx)
      REG_LONG_PRESS:   thr_long_press   = data[15:0];
      REG_TAP_WINDOW:   thr_tap_window   = data[15:0];
      REG_CHORD_WINDOW: thr_chord_window = data[15:0];
      REG_DOUBLE:       act_double       = data;
      REG_TRIPLE:       act_triple       = data;
      REG_LONG:         act_long         = data;
      REG_CHORD_LOW:    act_chord_lo     = data;
      REG_CHORD_HIGH:   act_chord_hi     = data[31:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] button_action(input logic [63:0] slots, input int btn);
    return slots[16*btn +: 16];
  endfunction

  // Pairs are numbered 0-1, 0-2, 0-3, 1-2, 1-3, 2-3 across both chord registers.
  function automatic logic [15:0] chord_action(input int a, input int b);
    logic [95:0] all_pairs;
    int          pair;
    all_pairs = {act_chord_hi, act_chord_lo};
    pair      = a * (7 - a) / 2 + (b - a - 1);
    return all_pairs[16*pair +: 16];
  endfunction

  function automatic bit is_mapped(input int btn);
    if (button_action(act_double, btn) != 0 || button_action(act_triple, btn) != 0 ||
        button_action(act_long, btn) != 0)
      return 1'b1;
    for (int j = 0; j < 4; j++) begin
      if (j != btn && chord_action(btn < j ? btn : j, btn < j ? j : btn) != 0)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_event(input ev_kind_e kind, input int first, input int second,
                                    input logic [15:0] act);
    event_t ev;
    if (tick_events.size() < EVENTS_PER_TICK) begin
      ev.kind     = kind;
      ev.first    = 2'(first);
      ev.second   = 2'(second);
      ev.modifier = act[15:8];
      ev.key      = act[7:0];
      ev.last     = 1'b0;
      tick_events.push_back(ev);
    end
  endfunction

  function automatic void predict_tick(input logic [3:0] edges, input logic [3:0] levels,
                                       input logic [31:0] now);
    event_t      ev;
    bit          pressed_edge;
    bit          held;
    bit          released;
    logic [31:0] span;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [15:0] act;
    tick_events.delete();
    for (int i = 0; i < 4; i++) begin
      pressed_edge = edges[i];
      held         = levels[i];
      released     = btn_prev[i] && !held;
      btn_prev[i]  = held;
      if (!is_mapped(i)) begin
        if (pressed_edge) add_event(EV_SINGLE, i, 0, 16'h0);
        btn_phase[i] = PH_IDLE;
        btn_taps[i]  = '0;
        continue;
      end
      case (btn_phase[i])
        PH_IDLE: begin
          if (pressed_edge) begin
            btn_phase[i]   = PH_HELD;
            btn_press_t[i] = now;
            btn_taps[i]    = 8'd1;
          end
        end
        PH_HELD: begin
          if (released) begin
            span = now - btn_press_t[i];
            if (span >= 32'(thr_long_press)) begin
              act = button_action(act_long, i);
              if (act != 0) add_event(EV_LONG, i, 0, act);
              else          add_event(EV_SINGLE, i, 0, 16'h0);
              btn_phase[i] = PH_IDLE;
              btn_taps[i]  = '0;
            end else begin
              btn_release_t[i] = now;
              btn_phase[i]     = PH_AWAIT;
            end
          end
        end
        PH_AWAIT: begin
          span = now - btn_release_t[i];
          if (pressed_edge) begin
            if (btn_taps[i] != 8'd255) btn_taps[i] = btn_taps[i] + 8'd1;
            btn_phase[i]   = PH_HELD;
            btn_press_t[i] = now;
          end else if (span > 32'(thr_tap_window)) begin
            if (btn_taps[i] == 8'd2 && button_action(act_double, i) != 0)
              add_event(EV_DOUBLE, i, 0, button_action(act_double, i));
            else if (btn_taps[i] == 8'd3 && button_action(act_triple, i) != 0)
              add_event(EV_TRIPLE, i, 0, button_action(act_triple, i));
            else if (btn_taps[i] == 8'd1)
              add_event(EV_SINGLE, i, 0, 16'h0);
            btn_phase[i] = PH_IDLE;
            btn_taps[i]  = '0;
          end
        end
        default: begin
          if (released) begin
            btn_phase[i] = PH_IDLE;
            btn_taps[i]  = '0;
          end
        end
      endcase
    end

    // A button that has just formed a chord is consumed, so it cannot join another.
    for (int a = 0; a < 4; a++) begin
      if (btn_phase[a] != PH_HELD) continue;
      for (int b = a + 1; b < 4; b++) begin
        if (btn_phase[b] != PH_HELD) continue;
        d1 = btn_press_t[a] - btn_press_t[b];
        d2 = btn_press_t[b] - btn_press_t[a];
        span = (d1 < d2) ? d1 : d2;
        if (span > 32'(thr_chord_window)) continue;
        act = chord_action(a, b);
        if (act == 0) continue;
        add_event(EV_CHORD, a, b, act);
        btn_phase[a] = PH_CONSUMED;
        btn_phase[b] = PH_CONSUMED;
        btn_taps[a]  = '0;
        btn_taps[b]  = '0;
        break;
      end
    end

    if (tick_events.size() > 0) begin
      ev      = tick_events[tick_events.size() - 1];
      ev.last = 1'b1;
      tick_events[tick_events.size() - 1] = ev;
    end
    foreach (tick_events[k]) expected_events.push_back(tick_events[k]);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event transfer with no event expected");
      end else begin
        oldest_event = expected_events.pop_front();
        check_field("event_kind",    8'(event_kind_o),    8'(oldest_event.kind));
        check_field("first_button",  8'(first_button_o),  8'(oldest_event.first));
        check_field("second_button", 8'(second_button_o), 8'(oldest_event.second));
        check_field("modifier_code", modifier_code_o,     oldest_event.modifier);
        check_field("key_code",      key_code_o,          oldest_event.key);
        check_field("last_event",    8'(last_event_o),    8'(oldest_event.last));
      end
    end
  end

  // Event receiver: random stalls, or one long hold-off on request.
  initial begin : receiver
    int k;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_receiver) begin
        out_ready_i <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
        hold_receiver = 1'b0;
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin
    #400_000;
    $display("tb_button_tap_long_chord_detector failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [3:0] edges, input logic [3:0] levels,
                           input logic [31:0] now);
    @(negedge clk_i);
    // Each cycle the sender idles with the same chance.
    while (!no_gaps && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    press_edge_mask_i <= edges;
    pressed_mask_i    <= levels;
    now_ms_i          <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tick(edges, levels, now);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering ticks and waits until every event has been seen, plus a
  // short settle for a tick that is still being resolved but gives no event.
  task automatic wait_for_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] lp, input logic [15:0] tw, input logic [15:0] cw,
                            input logic [63:0] dbl_act, input logic [63:0] tpl_act,
                            input logic [63:0] lng_act, input logic [63:0] chord_lo,
                            input logic [31:0] chord_hi);
    wait_for_quiet();
    write_reg(REG_LONG_PRESS,   64'(lp));
    write_reg(REG_TAP_WINDOW,   64'(tw));
    write_reg(REG_CHORD_WINDOW, 64'(cw));
    write_reg(REG_DOUBLE,       dbl_act);
    write_reg(REG_TRIPLE,       tpl_act);
    write_reg(REG_LONG,         lng_act);
    write_reg(REG_CHORD_LOW,    chord_lo);
    write_reg(REG_CHORD_HIGH,   64'(chord_hi));
  endtask

  function automatic logic [63:0] random_slots();
    logic [63:0] v;
    for (int s = 0; s < 4; s++)
      v[16*s +: 16] = ($urandom_range(2) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
    return v;
  endfunction

  // Buttons are pressed and released as a person would, with some raw noise.
  task automatic random_tick(input int step_max);
    logic [3:0] edges;
    logic [3:0] levels;
    int         pick;
    edges = '0;
    for (int i = 0; i < 4; i++) begin
      if (!sim_held[i]) begin
        if ($urandom_range(99) < 30) begin
          sim_held[i] = 1'b1;
          edges[i]    = 1'b1;
        end
      end else if ($urandom_range(99) < 35) begin
        sim_held[i] = 1'b0;
      end
    end
    levels = sim_held;
    if ($urandom_range(99) < 8) begin
      edges    = 4'($urandom);
      levels   = 4'($urandom);
      sim_held = levels;
    end
    pick = $urandom_range(99);
    if (pick >= 12)     sim_now += $urandom_range(1, step_max);
    else if (pick >= 6) sim_now += $urandom;
    send_tick(edges, levels, sim_now);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_unmapped_press();
    send_tick(4'hF, 4'hF, 32'd10);
    send_tick(4'h0, 4'h0, 32'd11);
    send_tick(4'h5, 4'h0, 32'd12);
  endtask

  // With nothing mapped every edge is a single event, so the event queue
  // fills quickly while the receiver is held off.
  task automatic test_output_backpressure();
    wait_for_quiet();
    hold_receiver = 1'b1;
    for (int t = 0; t < 10; t++) send_tick(4'hF, 4'hF, 32'(100 + t));
    wait_for_quiet();
  endtask

  task automatic test_long_press();
    set_config(16'd100, 16'd50, 16'd20, 64'h0000_0000_0102_0000, 64'h0,
               64'h0000_0000_0000_11A5, 64'h0, 32'h0);
    send_tick(4'h1, 4'h1, 32'd1000);
    send_tick(4'h1, 4'h1, 32'd1050);   // edge while held is ignored
    send_tick(4'h0, 4'h0, 32'd1100);   // hold time exactly at the threshold
    send_tick(4'h2, 4'h2, 32'd1200);
    send_tick(4'h0, 4'h0, 32'd1400);   // long release without a long mapping
    send_tick(4'h1, 4'h1, 32'hFFFF_FFC0);
    send_tick(4'h0, 4'h0, 32'h0000_0030);
  endtask

  task automatic test_tap_counts();
    set_config(16'd1000, 16'd100, 16'd20, 64'h0000_0203_0102_0000,
               64'h0304_0000_0000_0000, 64'h0000_0000_0000_11A5, 64'h0, 32'h0);
    // Button 0 taps four times, 1 once, 2 twice and 3 three times.
    send_tick(4'hF, 4'hF, 32'd2000);
    send_tick(4'h0, 4'h0, 32'd2010);
    send_tick(4'hD, 4'hD, 32'd2020);
    send_tick(4'h0, 4'h0, 32'd2030);
    send_tick(4'h9, 4'h9, 32'd2040);
    send_tick(4'h0, 4'h0, 32'd2050);
    send_tick(4'h1, 4'h1, 32'd2060);
    send_tick(4'h0, 4'h0, 32'd2070);
    send_tick(4'h0, 4'h0, 32'd2130);   // button 2 sits exactly on the tap window
    send_tick(4'h0, 4'h0, 32'd2131);
    send_tick(4'h0, 4'h0, 32'd2171);
  endtask

  task automatic test_chords();
    set_config(16'd1000, 16'd100, 16'd20, 64'h0, 64'h0, 64'h0,
               64'h0000_0000_0E0F_0A0B, 32'h0C0D_0000);
    send_tick(4'h3, 4'h3, 32'd5000);
    send_tick(4'h3, 4'h3, 32'd5005);   // edges on consumed buttons are ignored
    send_tick(4'h4, 4'h7, 32'd5010);
    send_tick(4'h8, 4'hF, 32'd5031);   // just outside the chord window
    send_tick(4'h0, 4'h0, 32'd5040);
    send_tick(4'h4, 4'h4, 32'd6000);
    send_tick(4'h8, 4'hC, 32'd6020);   // exactly on the chord window
    send_tick(4'h0, 4'h0, 32'd6030);
    send_tick(4'hF, 4'hF, 32'd7000);   // button 0 may join only one chord
    send_tick(4'h0, 4'h0, 32'd7010);
  endtask

  // More taps than the triple count give no event when the window closes.
  task automatic test_extra_taps();
    logic [31:0] t;
    set_config(16'd1000, 16'd100, 16'd0, 64'h0000_0000_0000_2222, 64'h0, 64'h0,
               64'h0, 32'h0);
    t = 32'd9000;
    for (int n = 0; n < 6; n++) begin
      send_tick(4'h1, 4'h1, t);
      send_tick(4'h0, 4'h0, t + 32'd1);
      t += 32'd2;
    end
    send_tick(4'h0, 4'h0, t + 32'd200);
  endtask

  task automatic test_random_traffic();
    // Short windows with a mix of mapped and unmapped slots.
    set_config(16'd150, 16'd60, 16'd25, random_slots(), random_slots(), random_slots(),
               random_slots(), 32'(random_slots()));
    sim_now = $urandom;
    for (int n = 0; n < RANDOM_TICKS; n++) random_tick(60);

    // Zero windows, every slot mapped, and no idling on either side.
    set_config(16'd0, 16'd0, 16'd0, '1, '1, '1, '1, '1);
    no_gaps = 1'b1;
    for (int n = 0; n < RANDOM_TICKS; n++) random_tick(3);
    no_gaps = 1'b0;

    // Widest windows with fully random action words.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    for (int n = 0; n < RANDOM_TICKS; n++) random_tick(200);

    // Nothing mapped: every edge is a single event.
    set_config(16'($urandom_range(100)), 16'($urandom_range(100)), 16'($urandom_range(100)),
               64'h0, 64'h0, 64'h0, 64'h0, 32'h0);
    for (int n = 0; n < RANDOM_TICKS; n++) random_tick(50);

    // Timestamps running across the wrap of the millisecond counter.
    set_config(16'd200, 16'd80, 16'd30, random_slots(), random_slots(), random_slots(),
               random_slots(), 32'(random_slots()));
    sim_now = 32'hFFFF_FF00 + 32'($urandom_range(200));
    for (int n = 0; n < RANDOM_TICKS; n++) random_tick(40);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    press_edge_mask_i = '0;
    pressed_mask_i    = '0;
    now_ms_i          = '0;
    sim_now           = '0;
    sim_held          = '0;
    clear_prediction();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_unmapped_press();
    test_output_backpressure();
    test_long_press();
    test_tap_counts();
    test_chords();
    test_extra_taps();
    test_random_traffic();

    wait_for_quiet();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_button_tap_long_chord_detector passed");
    end else begin
      $display("tb_button_tap_long_chord_detector failed");
    end
    $finish;
  end

endmodule
